// ===== rtl/core/lpe_pkg.sv =====
// Shared types and fixed field widths of the line plucker block.
// No dependencies; the top level, the interfaces, the output buffer and the testbench use it.
`timescale 1ns / 1ps
`default_nettype none
package lpe_pkg;

    localparam int DIR_FRAC  = 30;
    localparam int DIR_WIDTH = 32;
    localparam int MOM_WIDTH = 34;
    localparam int TAG_WIDTH = 16;

    typedef struct packed {
        logic [DIR_WIDTH-1:0] dir_x;
        logic [DIR_WIDTH-1:0] dir_y;
        logic [DIR_WIDTH-1:0] dir_z;
        logic [MOM_WIDTH-1:0] moment_x;
        logic [MOM_WIDTH-1:0] moment_y;
        logic [MOM_WIDTH-1:0] moment_z;
        logic [MOM_WIDTH-1:0] foot_x;
        logic [MOM_WIDTH-1:0] foot_y;
        logic [MOM_WIDTH-1:0] foot_z;
        logic                 degenerate;
        logic [TAG_WIDTH-1:0] tag_out;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/lpe_if.sv =====
// Segment and result channel interfaces of the line plucker block.
// Depends on lpe_pkg for the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lpe_seg_if #(parameter int COORD_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  start_x;
    logic signed [COORD_WIDTH-1:0]  start_y;
    logic signed [COORD_WIDTH-1:0]  start_z;
    logic signed [COORD_WIDTH-1:0]  end_x;
    logic signed [COORD_WIDTH-1:0]  end_y;
    logic signed [COORD_WIDTH-1:0]  end_z;
    logic [lpe_pkg::TAG_WIDTH-1:0]  line_tag;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    line_tag, input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    line_tag, output ready);
endinterface

interface lpe_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lpe_pkg::DIR_WIDTH-1:0] dir_x;
    logic signed [lpe_pkg::DIR_WIDTH-1:0] dir_y;
    logic signed [lpe_pkg::DIR_WIDTH-1:0] dir_z;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] moment_x;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] moment_y;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] moment_z;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] foot_x;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] foot_y;
    logic signed [lpe_pkg::MOM_WIDTH-1:0] foot_z;
    logic                                 degenerate;
    logic [lpe_pkg::TAG_WIDTH-1:0]        tag_out;

    modport source (output valid, dir_x, dir_y, dir_z, moment_x, moment_y, moment_z,
                    foot_x, foot_y, foot_z, degenerate, tag_out, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, moment_x, moment_y, moment_z,
                    foot_x, foot_y, foot_z, degenerate, tag_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/line_plucker_from_endpoints.sv =====
// Top level of the line plucker block: segment in, normalized Plucker line out.
// Depends on lpe_pkg, lpe_if, lpe_sqrt_cell, lpe_div_cell and lpe_out_buf.
//
// Usage: i_seg carries one segment per request (start and end points in
// signed Q16.16, COORD_WIDTH bits, plus a tag); o_res returns one result per
// request: unit direction in Q1.30, moment and foot point in Q17.16, the
// degenerate flag and the tag. A segment whose ends coincide gives zero
// vectors with degenerate set.
// Throughput: one request per cycle, sustained while the output buffer has room.
// Path: the input register and front stages, the square root chain (one root
// bit per cell), the division chain (one quotient bit per cell), then the
// saturation and foot point stages and the output buffer to o_res.valid.
// Stall: results collect in a two-entry output buffer; when both entries are
// full the whole pipeline holds and i_seg.ready is low until one is taken.
// Reset: clears the valid bits of every stage and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none
module line_plucker_from_endpoints #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpe_seg_if.sink   i_seg,
    lpe_res_if.source o_res
);
    import lpe_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int DW      = CW + 1;
    localparam int PW      = 2 * CW;
    localparam int MN_W    = PW + 1;
    localparam int SQ_BITS = CW + 1;
    localparam int L2_W    = 2 * SQ_BITS;
    localparam int NUM_W   = (2 * CW > CW + DIR_FRAC + 1) ? 2 * CW : CW + DIR_FRAC + 1;
    localparam int DIV_W   = SQ_BITS + NUM_W;
    localparam int N_LANES = 6;
    localparam int LANE_MOM = 3;
    localparam int SIDE2_W = N_LANES + 1 + TAG_WIDTH;
    localparam int SIDE1_W = N_LANES * NUM_W + SIDE2_W;
    localparam int FW      = DIR_WIDTH + MOM_WIDTH;
    localparam int FP_W    = FW + 1;
    localparam int FS_W    = FP_W - DIR_FRAC;
    localparam logic signed [DIR_WIDTH-1:0] DIR_ONE = DIR_WIDTH'(1) <<< DIR_FRAC;

    function automatic logic [NUM_W-1:0] f_sat_q(input logic [NUM_W-1:0] q,
                                                 input logic neg, input int w);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] m;
        lim = (NUM_W'(1) << (w - 1)) - {{(NUM_W-1){1'b0}}, ~neg};
        m   = (q > lim) ? lim : q;
        return neg ? (~m + NUM_W'(1)) : m;
    endfunction

    function automatic logic [MOM_WIDTH-1:0] f_foot(input logic signed [FP_W-1:0] p);
        logic             neg;
        logic [FP_W-1:0]  mag;
        logic [FS_W-1:0]  sh;
        logic [FS_W-1:0]  lim;
        logic [FS_W-1:0]  m;
        logic [FS_W-1:0]  v;
        neg = p[FP_W-1];
        mag = neg ? -p : p;
        sh  = mag[FP_W-1:DIR_FRAC];
        lim = (FS_W'(1) << (MOM_WIDTH - 1)) - {{(FS_W-1){1'b0}}, ~neg};
        m   = (sh > lim) ? lim : sh;
        v   = neg ? (~m + FS_W'(1)) : m;
        return v[MOM_WIDTH-1:0];
    endfunction

    logic w_en;
    logic w_push;

    // Input register.
    logic                 r_v0;
    logic signed [CW-1:0] r_s0 [3];
    logic signed [CW-1:0] r_e0 [3];
    logic [TAG_WIDTH-1:0] r_tag0;

    // Differences, products, sums and magnitudes.
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [TAG_WIDTH-1:0] r_tag1, r_tag2, r_tag3, r_tag4;
    logic signed [DW-1:0] r_d1 [3];
    logic signed [CW-1:0] r_s1 [3];
    logic signed [CW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic [L2_W-1:0]      r_sq2 [3];
    logic signed [PW-1:0] r_pa2 [3];
    logic signed [PW-1:0] r_pb2 [3];
    logic signed [DW-1:0] r_d3 [3];
    logic signed [MN_W-1:0] r_mn3 [3];
    logic [L2_W-1:0]      r_l2_3;
    logic [L2_W-1:0]      r_l2_4;
    logic                 r_deg4;
    logic [NUM_W-1:0]     r_num4 [N_LANES];
    logic                 r_neg4 [N_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_seg.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0[0] <= i_seg.start_x;
            r_s0[1] <= i_seg.start_y;
            r_s0[2] <= i_seg.start_z;
            r_e0[0] <= i_seg.end_x;
            r_e0[1] <= i_seg.end_y;
            r_e0[2] <= i_seg.end_z;
            r_tag0  <= i_seg.line_tag;
            r_tag1  <= r_tag0;
            r_tag2  <= r_tag1;
            r_tag3  <= r_tag2;
            r_tag4  <= r_tag3;
            r_l2_3  <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_l2_4  <= r_l2_3;
            r_deg4  <= (r_l2_3 == '0);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        logic [DW-1:0]   n_dmag;
        logic [MN_W-1:0] n_mmag;

        always_comb begin
            n_dmag = r_d3[i][DW-1] ? -r_d3[i] : r_d3[i];
            n_mmag = r_mn3[i][MN_W-1] ? -r_mn3[i] : r_mn3[i];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1[i]  <= DW'(r_e0[i]) - DW'(r_s0[i]);
                r_s1[i]  <= r_s0[i];
                r_e1[i]  <= r_e0[i];
                r_d2[i]  <= r_d1[i];
                r_sq2[i] <= L2_W'(r_d1[i]) * L2_W'(r_d1[i]);
                r_pa2[i] <= PW'(r_s1[J]) * PW'(r_e1[K]);
                r_pb2[i] <= PW'(r_s1[K]) * PW'(r_e1[J]);
                r_d3[i]  <= r_d2[i];
                r_mn3[i] <= MN_W'(r_pa2[i]) - MN_W'(r_pb2[i]);
                r_num4[i]            <= NUM_W'(n_dmag) << DIR_FRAC;
                r_neg4[i]            <= r_d3[i][DW-1];
                r_num4[LANE_MOM + i] <= NUM_W'(n_mmag);
                r_neg4[LANE_MOM + i] <= r_mn3[i][MN_W-1];
            end
        end
    end

    // Square root chain: the length, with the numerators carried alongside.
    logic [SQ_BITS+1:0]  w_sq_rem  [SQ_BITS+1];
    logic [SQ_BITS-1:0]  w_sq_root [SQ_BITS+1];
    logic [L2_W-1:0]     w_sq_rad  [SQ_BITS+1];
    logic [SIDE1_W-1:0]  w_sq_side [SQ_BITS+1];
    logic                w_sq_v    [SQ_BITS+1];
    logic [N_LANES-1:0][NUM_W-1:0] w_num_pk;
    logic [N_LANES-1:0]            w_neg_pk;

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            w_num_pk[l] = r_num4[l];
            w_neg_pk[l] = r_neg4[l];
        end
    end

    assign w_sq_v[0]    = r_v4;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = r_l2_4;
    assign w_sq_side[0] = {w_num_pk, w_neg_pk, r_deg4, r_tag4};

    for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
        lpe_sqrt_cell #(
            .SQ_BITS (SQ_BITS),
            .SIDE_W  (SIDE1_W)
        ) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_rad   (w_sq_rad[k]),
            .i_side  (w_sq_side[k]),
            .o_valid (w_sq_v[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_rad   (w_sq_rad[k+1]),
            .o_side  (w_sq_side[k+1])
        );
    end

    // Division chain: six quotients by the length.
    logic [N_LANES-1:0][DIV_W-1:0] w_dv_lane [NUM_W+1];
    logic [SQ_BITS-1:0]            w_dv_div  [NUM_W+1];
    logic [SIDE2_W-1:0]            w_dv_side [NUM_W+1];
    logic                          w_dv_v    [NUM_W+1];
    logic [N_LANES-1:0][NUM_W-1:0] w_sq_nums;

    assign w_sq_nums = w_sq_side[SQ_BITS][SIDE1_W-1:SIDE2_W];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            w_dv_lane[0][l] = {{SQ_BITS{1'b0}}, w_sq_nums[l]};
        end
    end

    assign w_dv_v[0]    = w_sq_v[SQ_BITS];
    assign w_dv_div[0]  = w_sq_root[SQ_BITS];
    assign w_dv_side[0] = w_sq_side[SQ_BITS][SIDE2_W-1:0];

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        lpe_div_cell #(
            .SQ_BITS (SQ_BITS),
            .NUM_W   (NUM_W),
            .LANES   (N_LANES),
            .SIDE_W  (SIDE2_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[k]),
            .i_div   (w_dv_div[k]),
            .i_lane  (w_dv_lane[k]),
            .i_side  (w_dv_side[k]),
            .o_valid (w_dv_v[k+1]),
            .o_div   (w_dv_div[k+1]),
            .o_lane  (w_dv_lane[k+1]),
            .o_side  (w_dv_side[k+1])
        );
    end

    // Saturation, signs, then the foot point products.
    logic [N_LANES-1:0]   w_q_neg;
    logic                 w_q_deg;
    logic [TAG_WIDTH-1:0] w_q_tag;

    assign w_q_neg = w_dv_side[NUM_W][SIDE2_W-1:TAG_WIDTH+1];
    assign w_q_deg = w_dv_side[NUM_W][TAG_WIDTH];
    assign w_q_tag = w_dv_side[NUM_W][TAG_WIDTH-1:0];

    logic                        r_v5, r_v6, r_v7, r_v8;
    logic                        r_deg5, r_deg6, r_deg7, r_deg8;
    logic [TAG_WIDTH-1:0]        r_tag5, r_tag6, r_tag7, r_tag8;
    logic signed [DIR_WIDTH-1:0] r_dir5 [3];
    logic signed [MOM_WIDTH-1:0] r_mom5 [3];
    logic signed [DIR_WIDTH-1:0] r_dir6 [3];
    logic signed [MOM_WIDTH-1:0] r_mom6 [3];
    logic signed [DIR_WIDTH-1:0] r_dir7 [3];
    logic signed [MOM_WIDTH-1:0] r_mom7 [3];
    logic signed [DIR_WIDTH-1:0] r_dir8 [3];
    logic signed [MOM_WIDTH-1:0] r_mom8 [3];
    logic signed [FW-1:0]        r_fa6 [3];
    logic signed [FW-1:0]        r_fb6 [3];
    logic signed [FP_W-1:0]      r_fp7 [3];
    logic [MOM_WIDTH-1:0]        r_foot8 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_dv_v[NUM_W];
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg5 <= w_q_deg;
            r_deg6 <= r_deg5;
            r_deg7 <= r_deg6;
            r_deg8 <= r_deg7;
            r_tag5 <= w_q_tag;
            r_tag6 <= r_tag5;
            r_tag7 <= r_tag6;
            r_tag8 <= r_tag7;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_out
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        logic [NUM_W-1:0] n_dir_sat;
        logic [NUM_W-1:0] n_mom_sat;

        assign n_dir_sat = f_sat_q(w_dv_lane[NUM_W][i][NUM_W-1:0], w_q_neg[i], DIR_WIDTH);
        assign n_mom_sat = f_sat_q(w_dv_lane[NUM_W][LANE_MOM + i][NUM_W-1:0],
                                   w_q_neg[LANE_MOM + i], MOM_WIDTH);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                // A zero-length segment divides by zero; its vectors are forced clear.
                r_dir5[i]  <= w_q_deg ? '0 : n_dir_sat[DIR_WIDTH-1:0];
                r_mom5[i]  <= w_q_deg ? '0 : n_mom_sat[MOM_WIDTH-1:0];
                r_dir6[i]  <= r_dir5[i];
                r_mom6[i]  <= r_mom5[i];
                r_fa6[i]   <= FW'(r_dir5[J]) * FW'(r_mom5[K]);
                r_fb6[i]   <= FW'(r_dir5[K]) * FW'(r_mom5[J]);
                r_dir7[i]  <= r_dir6[i];
                r_mom7[i]  <= r_mom6[i];
                r_fp7[i]   <= FP_W'(r_fa6[i]) - FP_W'(r_fb6[i]);
                r_dir8[i]  <= r_dir7[i];
                r_mom8[i]  <= r_mom7[i];
                r_foot8[i] <= f_foot(r_fp7[i]);
            end
        end
    end

    t_result w_res;

    always_comb begin
        w_res.dir_x      = r_dir8[0];
        w_res.dir_y      = r_dir8[1];
        w_res.dir_z      = r_dir8[2];
        w_res.moment_x   = r_mom8[0];
        w_res.moment_y   = r_mom8[1];
        w_res.moment_z   = r_mom8[2];
        w_res.foot_x     = r_foot8[0];
        w_res.foot_y     = r_foot8[1];
        w_res.foot_z     = r_foot8[2];
        w_res.degenerate = r_deg8;
        w_res.tag_out    = r_tag8;
    end

    assign w_push      = r_v8 && w_en;
    assign i_seg.ready = w_en;

    lpe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_room  (w_en),
        .o_res   (o_res)
    );

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_res.valid)
        else $error("result pushed into the buffer but not offered");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.degenerate) |->
            (o_res.dir_x == '0 && o_res.dir_y == '0 && o_res.dir_z == '0 &&
             o_res.moment_x == '0 && o_res.moment_y == '0 && o_res.moment_z == '0 &&
             o_res.foot_x == '0 && o_res.foot_y == '0 && o_res.foot_z == '0))
        else $error("degenerate result with non-zero vectors");

    a_dir_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
            (o_res.dir_x <= DIR_ONE && o_res.dir_x >= -DIR_ONE &&
             o_res.dir_y <= DIR_ONE && o_res.dir_y >= -DIR_ONE &&
             o_res.dir_z <= DIR_ONE && o_res.dir_z >= -DIR_ONE))
        else $error("direction component beyond one");
endmodule
`default_nettype wire

// ===== rtl/core/lpe_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cycle while i_en is high.
// Self-contained; chained by the top level, with a side word carried along.
`timescale 1ns / 1ps
`default_nettype none
module lpe_sqrt_cell #(
    parameter int SQ_BITS = 33,
    parameter int SIDE_W  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SQ_BITS+1:0]   i_rem,
    input  logic [SQ_BITS-1:0]   i_root,
    input  logic [2*SQ_BITS-1:0] i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [SQ_BITS+1:0]   o_rem,
    output logic [SQ_BITS-1:0]   o_root,
    output logic [2*SQ_BITS-1:0] o_rad,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int REM_W = SQ_BITS + 2;
    localparam int RAD_W = 2 * SQ_BITS;

    logic [REM_W-1:0]   n_rem_sh;
    logic [REM_W-1:0]   n_trial;
    logic               n_take;
    logic               r_valid;
    logic [REM_W-1:0]   r_rem;
    logic [SQ_BITS-1:0] r_root;
    logic [RAD_W-1:0]   r_rad;
    logic [SIDE_W-1:0]  r_side;

    // The top two bits of the partial remainder are always clear here, so
    // dropping them on the shift loses nothing.
    assign n_rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1 -: 2]};
    assign n_trial  = {i_root, 2'b01};
    assign n_take   = (n_rem_sh >= n_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_take ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {i_root[SQ_BITS-2:0], n_take};
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ===== rtl/core/lpe_div_cell.sv =====
// One cell of the division chain: one restoring quotient bit per lane.
// Self-contained; all lanes share the divisor that travels with them.
`timescale 1ns / 1ps
`default_nettype none
module lpe_div_cell #(
    parameter int SQ_BITS = 33,
    parameter int NUM_W   = 64,
    parameter int LANES   = 6,
    parameter int SIDE_W  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [SQ_BITS-1:0]                  i_div,
    input  logic [LANES-1:0][SQ_BITS+NUM_W-1:0] i_lane,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic [SQ_BITS-1:0]                  o_div,
    output logic [LANES-1:0][SQ_BITS+NUM_W-1:0] o_lane,
    output logic [SIDE_W-1:0]                   o_side
);
    localparam int W = SQ_BITS + NUM_W;

    logic [LANES-1:0][W-1:0] n_lane;
    logic                    r_valid;
    logic [SQ_BITS-1:0]      r_div;
    logic [LANES-1:0][W-1:0] r_lane;
    logic [SIDE_W-1:0]       r_side;

    // Each lane holds the partial remainder above the dividend bits still to
    // come; quotient bits fill in from the bottom as the dividend shifts out.
    always_comb begin
        logic [SQ_BITS:0] top;
        logic [SQ_BITS:0] diff;
        for (int l = 0; l < LANES; l++) begin
            top  = i_lane[l][W-1:NUM_W-1];
            diff = top - {1'b0, i_div};
            if (top >= {1'b0, i_div}) begin
                n_lane[l] = {diff[SQ_BITS-1:0], i_lane[l][NUM_W-2:0], 1'b1};
            end else begin
                n_lane[l] = {top[SQ_BITS-1:0], i_lane[l][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_lane <= n_lane;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_lane  = r_lane;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ===== rtl/core/lpe_out_buf.sv =====
// Two-entry output buffer that drives the result channel.
// Depends on lpe_pkg (t_result) and lpe_if (lpe_res_if).
`timescale 1ns / 1ps
`default_nettype none
module lpe_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lpe_pkg::t_result i_data,
    output logic             o_room,
    lpe_res_if.source        o_res
);
    import lpe_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       n_pop;
    t_result    n_head;

    assign n_pop  = o_res.valid && o_res.ready;
    assign n_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Room is taken from the count alone, so the pipeline never waits on
    // the receiver's ready within the same cycle.
    assign o_room = (r_count != 2'd2);

    assign o_res.valid      = (r_count != 2'd0);
    assign o_res.dir_x      = n_head.dir_x;
    assign o_res.dir_y      = n_head.dir_y;
    assign o_res.dir_z      = n_head.dir_z;
    assign o_res.moment_x   = n_head.moment_x;
    assign o_res.moment_y   = n_head.moment_y;
    assign o_res.moment_z   = n_head.moment_z;
    assign o_res.foot_x     = n_head.foot_x;
    assign o_res.foot_y     = n_head.foot_y;
    assign o_res.foot_z     = n_head.foot_z;
    assign o_res.degenerate = n_head.degenerate;
    assign o_res.tag_out    = n_head.tag_out;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for line_plucker_from_endpoints: segments in, Plucker lines out.
// Depends on lpe_pkg, lpe_if and line_plucker_from_endpoints; predicts each line with wide exact arithmetic.
`timescale 1ns / 1ps
module tb_top;
    import lpe_pkg::*;

    localparam int CW         = 32;
    localparam int RAND_COUNT = 1900;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 120;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
        logic [TAG_WIDTH-1:0] tag;
        bit                   drain;
    } t_segment;

    logic i_clk;
    logic i_rst_n;

    lpe_seg_if #(.COORD_WIDTH(CW)) seg_bus ();
    lpe_res_if                     res_bus ();

    line_plucker_from_endpoints #(.COORD_WIDTH(CW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_res   (res_bus)
    );

    t_segment segments_pending[$];
    t_result  lines_expected[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       sender_burst = 0;
    bit       receiver_burst = 0;

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        seg_bus.valid   = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.start_z = '0;
        seg_bus.end_x   = '0;
        seg_bus.end_y   = '0;
        seg_bus.end_z   = '0;
        seg_bus.line_tag = '0;
        res_bus.ready   = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_wide clamp(t_wide v, int w);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (w - 1)) - 1;
        lo = -(t_wide'(1) <<< (w - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Exact Plucker line of one segment, truncating every division toward zero.
    function automatic t_result plucker_line(t_segment g);
        t_result r;
        t_wide s[3], e[3], d[3], dv[3], mv[3], fv[3];
        t_wide sq, len, c;
        int j, k;
        s[0] = t_wide'(g.sx); s[1] = t_wide'(g.sy); s[2] = t_wide'(g.sz);
        e[0] = t_wide'(g.ex); e[1] = t_wide'(g.ey); e[2] = t_wide'(g.ez);
        r = '0;
        r.tag_out = g.tag;
        for (int i = 0; i < 3; i++) d[i] = e[i] - s[i];
        sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (sq == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        len = 0;
        for (int b = 51; b >= 0; b--) begin
            c = len | (t_wide'(1) <<< b);
            if (c * c <= sq) len = c;
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            dv[i] = clamp((d[i] <<< DIR_FRAC) / len, DIR_WIDTH);
            mv[i] = clamp((s[j] * e[k] - s[k] * e[j]) / len, MOM_WIDTH);
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            fv[i] = clamp((dv[j] * mv[k] - dv[k] * mv[j]) / (t_wide'(1) <<< DIR_FRAC),
                          MOM_WIDTH);
        end
        r.dir_x = dv[0][DIR_WIDTH-1:0];
        r.dir_y = dv[1][DIR_WIDTH-1:0];
        r.dir_z = dv[2][DIR_WIDTH-1:0];
        r.moment_x = mv[0][MOM_WIDTH-1:0];
        r.moment_y = mv[1][MOM_WIDTH-1:0];
        r.moment_z = mv[2][MOM_WIDTH-1:0];
        r.foot_x = fv[0][MOM_WIDTH-1:0];
        r.foot_y = fv[1][MOM_WIDTH-1:0];
        r.foot_z = fv[2][MOM_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [TAG_WIDTH-1:0] tag,
                                   logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("MISMATCH %0t tag %h %s: got %h expected %h", $realtime, tag, field,
                 got, want);
    endtask

    // Sender: one segment per request, random gaps, occasionally waits for a drain.
    int     send_gap = 0;
    always @(posedge i_clk) begin
        t_segment g;
        bit       busy;
        bit       valid_next;
        if (!i_rst_n) begin
            seg_bus.valid <= 1'b0;
        end else begin
            busy = seg_bus.valid;
            valid_next = seg_bus.valid;
            if (seg_bus.valid && seg_bus.ready) begin
                busy = 1'b0;
                valid_next = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (segments_pending.size() > 0 &&
                             !(segments_pending[0].drain && lines_expected.size() != 0)) begin
                    g = segments_pending.pop_front();
                    seg_bus.start_x  <= g.sx;
                    seg_bus.start_y  <= g.sy;
                    seg_bus.start_z  <= g.sz;
                    seg_bus.end_x    <= g.ex;
                    seg_bus.end_y    <= g.ey;
                    seg_bus.end_z    <= g.ez;
                    seg_bus.line_tag <= g.tag;
                    lines_expected.push_back(plucker_line(g));
                    valid_next = 1'b1;
                    if ($urandom_range(0, 99) < 3) sender_burst = ~sender_burst;
                    send_gap = sender_burst ? 0 : $urandom_range(0, 9);
                end
            end
            seg_bus.valid <= valid_next;
        end
    end

    // Receiver: checks each result against the oldest expected line.
    int recv_stall = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (lines_expected.size() == 0) begin
                    report_mismatch("unexpected", res_bus.tag_out, '0, '0);
                end else begin
                    want = lines_expected.pop_front();
                    if (res_bus.dir_x !== want.dir_x)
                        report_mismatch("dir_x", want.tag_out, 64'(res_bus.dir_x),
                                        64'(want.dir_x));
                    if (res_bus.dir_y !== want.dir_y)
                        report_mismatch("dir_y", want.tag_out, 64'(res_bus.dir_y),
                                        64'(want.dir_y));
                    if (res_bus.dir_z !== want.dir_z)
                        report_mismatch("dir_z", want.tag_out, 64'(res_bus.dir_z),
                                        64'(want.dir_z));
                    if (res_bus.moment_x !== want.moment_x)
                        report_mismatch("moment_x", want.tag_out, 64'(res_bus.moment_x),
                                        64'(want.moment_x));
                    if (res_bus.moment_y !== want.moment_y)
                        report_mismatch("moment_y", want.tag_out, 64'(res_bus.moment_y),
                                        64'(want.moment_y));
                    if (res_bus.moment_z !== want.moment_z)
                        report_mismatch("moment_z", want.tag_out, 64'(res_bus.moment_z),
                                        64'(want.moment_z));
                    if (res_bus.foot_x !== want.foot_x)
                        report_mismatch("foot_x", want.tag_out, 64'(res_bus.foot_x),
                                        64'(want.foot_x));
                    if (res_bus.foot_y !== want.foot_y)
                        report_mismatch("foot_y", want.tag_out, 64'(res_bus.foot_y),
                                        64'(want.foot_y));
                    if (res_bus.foot_z !== want.foot_z)
                        report_mismatch("foot_z", want.tag_out, 64'(res_bus.foot_z),
                                        64'(want.foot_z));
                    if (res_bus.degenerate !== want.degenerate)
                        report_mismatch("degenerate", want.tag_out, 64'(res_bus.degenerate),
                                        64'(want.degenerate));
                    if (res_bus.tag_out !== want.tag_out)
                        report_mismatch("tag_out", want.tag_out, 64'(res_bus.tag_out),
                                        64'(want.tag_out));
                end
                if ($urandom_range(0, 99) < 3) receiver_burst = ~receiver_burst;
                recv_stall = receiver_burst ? 0 : $urandom_range(0, 9);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            res_bus.ready <= (recv_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_bus.valid && seg_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    3: return 32'sh0001_0000;
                    default: return -32'sh0001_0000;
                endcase
            end
        endcase
    endfunction

    function automatic t_segment make_segment(logic signed [CW-1:0] sx, sy, sz, ex, ey, ez,
                                              logic [TAG_WIDTH-1:0] tag);
        t_segment g;
        g.sx = sx; g.sy = sy; g.sz = sz;
        g.ex = ex; g.ey = ey; g.ez = ez;
        g.tag = tag;
        g.drain = 0;
        return g;
    endfunction

    initial begin
        t_segment g;
        int       mode;
        logic signed [CW-1:0] mx, mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        // Directed: extremes, coincident ends, axis lines and the longest diagonals.
        segments_pending.push_back(make_segment(0, 0, 0, 0, 0, 0, 16'h0000));
        segments_pending.push_back(make_segment(mx, mx, mx, mx, mx, mx, 16'hffff));
        segments_pending.push_back(make_segment(mn, mn, mn, mn, mn, mn, 16'h0001));
        segments_pending.push_back(make_segment(mn, mn, mn, mx, mx, mx, 16'h0002));
        segments_pending.push_back(make_segment(mx, mx, mx, mn, mn, mn, 16'h0003));
        segments_pending.push_back(make_segment(mn, mx, mn, mx, mn, mx, 16'h0004));
        segments_pending.push_back(make_segment(0, 0, 0, 32'sh0001_0000, 0, 0, 16'h0005));
        segments_pending.push_back(make_segment(0, 0, 0, 0, -32'sh0001_0000, 0, 16'h0006));
        segments_pending.push_back(make_segment(0, 0, 0, 0, 0, 1, 16'h0007));
        segments_pending.push_back(make_segment(mx, 0, 0, mx, 0, 1, 16'h0008));
        segments_pending.push_back(make_segment(mx, mn, 0, mn, mx, 0, 16'h0009));
        segments_pending.push_back(make_segment(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0,
                                                16'h000a));
        segments_pending.push_back(make_segment(mx, 0, mn, mx, 1, mn, 16'h000b));
        segments_pending.push_back(make_segment(mn, 0, 0, mx, 0, 0, 16'haaaa));
        segments_pending.push_back(make_segment(0, mn, mx, 0, mx, mn, 16'h5555));
        segments_pending.push_back(make_segment(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0100,
                                                32'sh1234_5678, -32'sh0765_4321,
                                                32'sh0000_0100, 16'h8000));
        // Random part: full-range, small and extreme segments in equal share, some coincident or near-coincident.
        for (int n = 0; n < RAND_COUNT; n++) begin
            mode = $urandom_range(0, 2);
            g = make_segment(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                             pick_coord(mode), pick_coord(mode), pick_coord(mode),
                             TAG_WIDTH'($urandom));
            case ($urandom_range(0, 9))
                0: begin
                    g.ex = g.sx; g.ey = g.sy; g.ez = g.sz;
                end
                1: begin
                    g.ex = g.sx + $signed($urandom_range(0, 6)) - 3;
                    g.ey = g.sy + $signed($urandom_range(0, 6)) - 3;
                    g.ez = g.sz + $signed($urandom_range(0, 6)) - 3;
                end
                default: ;
            endcase
            g.drain = (n == 0) || (n == RAND_COUNT / 2);
            segments_pending.push_back(g);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (segments_pending.size() == 0);
        @(posedge i_clk);
        while (seg_bus.valid) @(posedge i_clk);
        wait (lines_expected.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
